>>> hw/rtl/iambic_keyer_core_assert.svh
// Assertion macros for the iambic keyer core.
// Expects clk and rst to be visible in the including scope.
`ifndef IAMBIC_KEYER_CORE_ASSERT_SVH
`define IAMBIC_KEYER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iambic keyer: implication check failed");

// Next-cycle implication, disabled during reset.
`define IK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iambic keyer: next-cycle check failed");

`endif

>>> hw/rtl/ik_pkg.sv
// Shared constants for the iambic keyer core: field widths, phase codes,
// key event codes, configuration register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package ik_pkg;

  localparam int DIT_LEN_W  = 10;
  localparam int TIMEOUT_W  = 16;
  localparam int TIME_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int EVENT_W    = 2;
  localparam int PHASE_W    = 2;

  // phases
  localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_TONE  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_SPACE = 2'd2;

  // key events
  localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
  localparam logic [EVENT_W-1:0] EV_DIT  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DAH  = 2'd2;
  localparam logic [EVENT_W-1:0] EV_UP   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIT_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_B     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd2;

  localparam logic [DIT_LEN_W-1:0] DIT_LEN_RESET = 10'd48;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;

endpackage

>>> hw/rtl/ik_span.sv
// Element duration: one or three dit lengths, saturated to the counter width.
// Depends on ik_pkg for the dit length width.
`timescale 1ns / 1ps

module ik_span #(
  parameter int COUNT_WIDTH = 12
) (
  input  logic [ik_pkg::DIT_LEN_W-1:0] dit_length,
  input  logic                         triple,
  output logic [COUNT_WIDTH-1:0]       span
);

  // 3 * 1023 needs two more bits than the dit length
  localparam int FULL_W = ik_pkg::DIT_LEN_W + 2;
  localparam int EXT_W  = (COUNT_WIDTH > FULL_W) ? COUNT_WIDTH : FULL_W;
  localparam logic [EXT_W-1:0] CAP = EXT_W'({COUNT_WIDTH{1'b1}});

  logic [FULL_W-1:0] base;
  logic [FULL_W-1:0] full;
  logic [EXT_W-1:0]  full_ext;

  always_comb begin
    // zero length acts as one tick
    base = (dit_length == '0) ? FULL_W'(1) : FULL_W'(dit_length);
    full = triple ? (base + (base << 1)) : base;
    full_ext = EXT_W'(full);
    span = (full_ext > CAP) ? COUNT_WIDTH'(CAP) : COUNT_WIDTH'(full_ext);
  end

endmodule

>>> hw/rtl/iambic_keyer_core.sv
// Iambic Morse keyer core, modes A and B, one millisecond tick per transaction.
// An accepted tick waits in the input register until it can advance; its result is then registered.
// Throughput: one tick per cycle while the output is not stalled; one input register and one result register.
// Reset (rst, synchronous): idle phase, counters and latches cleared,
// registers back to dit 48 ticks, mode A, timeout 5000 ticks.
// Depends on ik_pkg, ik_span and iambic_keyer_core_assert.svh.
`timescale 1ns / 1ps

module iambic_keyer_core #(
  parameter int COUNT_WIDTH = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [ik_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ik_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           dit_paddle,
  input  logic                           dah_paddle,
  input  logic                           stop_request,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           key_active,
  output logic [ik_pkg::EVENT_W-1:0]     key_event
);

  `include "iambic_keyer_core_assert.svh"

  // configuration
  logic [ik_pkg::DIT_LEN_W-1:0] dit_length;
  logic                         mode_b;
  logic [ik_pkg::TIMEOUT_W-1:0] timeout;

  // input register
  logic in_full;
  logic dit_q, dah_q, stop_q;

  // keyer state
  logic [ik_pkg::PHASE_W-1:0] phase, phase_next;
  logic [COUNT_WIDTH-1:0]     countdown, countdown_next;
  logic [ik_pkg::TIME_W-1:0]  time_in_phase, time_in_phase_next;
  logic                       last_was_dit, last_was_dit_next;
  logic                       dit_latch, dit_latch_next;
  logic                       dah_latch, dah_latch_next;
  logic [1:0]                 tone_snap, tone_snap_next;
  logic [1:0]                 space_snap, space_snap_next;

  logic                       key_active_next;
  logic [ik_pkg::EVENT_W-1:0] key_event_next;

  logic advance;
  logic [COUNT_WIDTH-1:0] span_dit, span_dah;

  assign advance  = in_full && !(out_valid && out_stall);
  assign in_stall = in_full && !advance;

  ik_span #(.COUNT_WIDTH(COUNT_WIDTH)) u_span_dit (
    .dit_length (dit_length),
    .triple     (1'b0),
    .span       (span_dit)
  );

  ik_span #(.COUNT_WIDTH(COUNT_WIDTH)) u_span_dah (
    .dit_length (dit_length),
    .triple     (1'b1),
    .span       (span_dah)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dit_length <= ik_pkg::DIT_LEN_RESET;
      mode_b     <= 1'b0;
      timeout    <= ik_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ik_pkg::CFG_DIT_LENGTH: dit_length <= cfg_data[ik_pkg::DIT_LEN_W-1:0];
        ik_pkg::CFG_MODE_B:     mode_b     <= cfg_data[0];
        ik_pkg::CFG_TIMEOUT:    timeout    <= cfg_data[ik_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // element choice at space end (post-update latches) or from idle (stored latches)
  function automatic logic [ik_pkg::EVENT_W-1:0] pick(
    input logic       dit,
    input logic       dah,
    input logic       from_idle,
    input logic       lwd,
    input logic       dit_l,
    input logic       dah_l,
    input logic [1:0] snap,
    input logic       mode_b_en
  );
    logic [ik_pkg::EVENT_W-1:0] kind;
    kind = ik_pkg::EV_NONE;
    if (from_idle || lwd) begin
      priority if (dah_l || dah) kind = ik_pkg::EV_DAH;
      else if (dit_l || dit)     kind = ik_pkg::EV_DIT;
      else if (mode_b_en && snap[1]) kind = ik_pkg::EV_DAH;
      else kind = ik_pkg::EV_NONE;
    end else begin
      priority if (dit_l || dit) kind = ik_pkg::EV_DIT;
      else if (dah_l || dah)     kind = ik_pkg::EV_DAH;
      else if (mode_b_en && snap[0]) kind = ik_pkg::EV_DIT;
      else kind = ik_pkg::EV_NONE;
    end
    if (from_idle && dit && dah) kind = ik_pkg::EV_DIT;
    return kind;
  endfunction

  always_comb begin
    logic                       busy;
    logic [ik_pkg::TIME_W-1:0]  tip_inc;
    logic [COUNT_WIDTH-1:0]     cd_dec;
    logic                       dit_l_upd, dah_l_upd;
    logic [ik_pkg::EVENT_W-1:0] kind;
    logic                       go_idle;
    logic                       start_tone;

    phase_next         = phase;
    countdown_next     = countdown;
    time_in_phase_next = time_in_phase;
    last_was_dit_next  = last_was_dit;
    dit_latch_next     = dit_latch;
    dah_latch_next     = dah_latch;
    tone_snap_next     = tone_snap;
    space_snap_next    = space_snap;
    key_event_next     = ik_pkg::EV_NONE;
    go_idle            = 1'b0;
    start_tone         = 1'b0;

    busy = (phase == ik_pkg::PH_TONE) || (phase == ik_pkg::PH_SPACE);
    tip_inc = (time_in_phase == '1) ? time_in_phase : time_in_phase + 1'b1;
    cd_dec = (countdown != '0) ? countdown - 1'b1 : countdown;

    dit_l_upd = dit_latch;
    dah_l_upd = dah_latch;
    if (phase == ik_pkg::PH_TONE) begin
      if (last_was_dit && dah_q && !tone_snap[1]) dah_l_upd = 1'b1;
      if (!last_was_dit && dit_q && !tone_snap[0]) dit_l_upd = 1'b1;
    end else begin
      if (dit_q && !space_snap[0]) dit_l_upd = 1'b1;
      if (dah_q && !space_snap[1]) dah_l_upd = 1'b1;
    end

    kind = pick(dit_q, dah_q, !busy, last_was_dit, busy ? dit_l_upd : dit_latch,
                busy ? dah_l_upd : dah_latch, tone_snap, mode_b);

    priority if (stop_q || (busy && (tip_inc > timeout))) begin
      if (phase == ik_pkg::PH_TONE) key_event_next = ik_pkg::EV_UP;
      go_idle = 1'b1;
    end else if (!busy) begin
      if ((dit_q || dah_q) && (kind != ik_pkg::EV_NONE)) start_tone = 1'b1;
    end else begin
      time_in_phase_next = tip_inc;
      dit_latch_next     = dit_l_upd;
      dah_latch_next     = dah_l_upd;
      countdown_next     = cd_dec;
      if (cd_dec == '0) begin
        if (phase == ik_pkg::PH_TONE) begin
          key_event_next     = ik_pkg::EV_UP;
          phase_next         = ik_pkg::PH_SPACE;
          time_in_phase_next = '0;
          space_snap_next    = {dah_q, dit_q};
          countdown_next     = span_dit;
        end else if (kind != ik_pkg::EV_NONE) begin
          start_tone = 1'b1;
        end else begin
          go_idle = 1'b1;
        end
      end
    end

    if (start_tone) begin
      key_event_next     = kind;
      tone_snap_next     = {dah_q, dit_q};
      dit_latch_next     = 1'b0;
      dah_latch_next     = 1'b0;
      last_was_dit_next  = (kind == ik_pkg::EV_DIT);
      phase_next         = ik_pkg::PH_TONE;
      time_in_phase_next = '0;
      countdown_next     = (kind == ik_pkg::EV_DIT) ? span_dit : span_dah;
    end

    if (go_idle) begin
      phase_next         = ik_pkg::PH_IDLE;
      countdown_next     = '0;
      time_in_phase_next = '0;
      dit_latch_next     = 1'b0;
      dah_latch_next     = 1'b0;
      tone_snap_next     = '0;
      space_snap_next    = '0;
    end

    key_active_next = (phase_next == ik_pkg::PH_TONE);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full       <= 1'b0;
      out_valid     <= 1'b0;
      phase         <= ik_pkg::PH_IDLE;
      countdown     <= '0;
      time_in_phase <= '0;
      last_was_dit  <= 1'b0;
      dit_latch     <= 1'b0;
      dah_latch     <= 1'b0;
      tone_snap     <= '0;
      space_snap    <= '0;
    end else begin
      if (in_valid && !in_stall) in_full <= 1'b1;
      else if (advance)          in_full <= 1'b0;

      if (advance)         out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      if (advance) begin
        phase         <= phase_next;
        countdown     <= countdown_next;
        time_in_phase <= time_in_phase_next;
        last_was_dit  <= last_was_dit_next;
        dit_latch     <= dit_latch_next;
        dah_latch     <= dah_latch_next;
        tone_snap     <= tone_snap_next;
        space_snap    <= space_snap_next;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      dit_q  <= dit_paddle;
      dah_q  <= dah_paddle;
      stop_q <= stop_request;
    end
    if (advance) begin
      key_active <= key_active_next;
      key_event  <= key_event_next;
    end
  end

  `IK_ASSERT_IMP(a_keydown_active,
                 out_valid && (key_event == ik_pkg::EV_DIT || key_event == ik_pkg::EV_DAH),
                 key_active)
  `IK_ASSERT_IMP(a_keyup_inactive, out_valid && key_event == ik_pkg::EV_UP, !key_active)
  `IK_ASSERT_IMP(a_idle_clean, phase == ik_pkg::PH_IDLE,
                 countdown == '0 && !dit_latch && !dah_latch && time_in_phase == '0)
  `IK_ASSERT_NXT(a_advance_result, advance, out_valid)

endmodule
